[src/apbc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apbc_pkg
// Shared codes, result type and the volume-to-gain table of the playback
// buffer control core.
// ----------------------------------------------------------------------------
package apbc_pkg;

  localparam int unsigned VolumeSteps   = 100;
  localparam int unsigned GainIdxW      = $clog2(VolumeSteps + 1);
  localparam int unsigned DefaultVolume = VolumeSteps / 2;

  localparam logic [63:0] Ln2Q30 = 64'd744261118;

  // request kinds, codes above sample act as tick
  localparam logic [2:0] ReqStart  = 3'd0;
  localparam logic [2:0] ReqStop   = 3'd1;
  localparam logic [2:0] ReqVolume = 3'd2;
  localparam logic [2:0] ReqTick   = 3'd3;
  localparam logic [2:0] ReqSample = 3'd4;

  localparam logic [1:0] ModeIdle      = 2'd0;
  localparam logic [1:0] ModeBuffering = 2'd1;
  localparam logic [1:0] ModeRunning   = 2'd2;

  localparam logic [1:0] RepNone      = 2'd0;
  localparam logic [1:0] RepBuffering = 2'd1;
  localparam logic [1:0] RepRunning   = 2'd2;
  localparam logic [1:0] RepStopped   = 2'd3;

  localparam logic [3:0] CfgLowWatermark  = 4'd0;
  localparam logic [3:0] CfgHighWatermark = 4'd1;

  typedef struct packed {
    logic [1:0]         mode;
    logic               output_enable;
    logic [1:0]         report;
    logic               rate_load;
    logic [17:0]        rate_out;
    logic               sample_valid;
    logic signed [15:0] scaled_sample;
    logic               last_result;
  } result_t;

  typedef struct packed {
    logic    valid;
    logic    two;
    result_t first;
    result_t second;
  } push_t;

  typedef logic [VolumeSteps:0][15:0] gain_tbl_t;

  // unsigned long division, shift and subtract, table build only
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // q15 gain of 1e-3 * exp(6.908 * v / steps), exact integer series
  function automatic logic [15:0] gain_for(int unsigned v);
    logic [63:0] x;
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] g;
    if (v == 0) begin
      return 16'd0;
    end
    x = udiv64((64'd6908 * 64'(v)) << 30, 64'd1000 * 64'(VolumeSteps));
    n = udiv64(x, Ln2Q30);
    r = x - n * Ln2Q30;
    sum  = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int k = 1; k <= 24; k++) begin
      term = udiv64((term * r) >> 30, 64'(k));
      sum  = sum + term;
    end
    if (n > 64'd12) begin
      return 16'h7fff;
    end
    g = udiv64((sum * 64'd32768) << n, 64'd1000 << 30);
    return (g > 64'd32767) ? 16'h7fff : g[15:0];
  endfunction

  function automatic gain_tbl_t build_gain_table();
    gain_tbl_t t;
    for (int v = 0; v <= VolumeSteps; v++) begin
      t[v] = gain_for(v);
    end
    return t;
  endfunction

  localparam gain_tbl_t GainTable = build_gain_table();

endpackage

[src/apbc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apbc_ctrl
// Input register, mode and gain state, watermark hysteresis and sample
// scaling; hands one or two results per item to the output queue.
// ----------------------------------------------------------------------------
module apbc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            req_type_i,
  input  logic [17:0]           rate_request_i,
  input  logic [7:0]            volume_percent_i,
  input  logic [15:0]           fill_level_i,
  input  logic signed [15:0]    sample_in_i,
  input  logic                  buffer_end_i,
  input  logic                  cfg_valid_i,
  input  logic [3:0]            cfg_addr_i,
  input  logic [15:0]           cfg_data_i,
  input  logic                  room_i,
  output apbc_pkg::push_t       push_o
);
  import apbc_pkg::*;

  logic               in_valid_q;
  logic [2:0]         req_q;
  logic [17:0]        rate_q;
  logic [7:0]         vol_q;
  logic [15:0]        fill_q;
  logic signed [15:0] sample_q;
  logic               bend_q;

  logic [15:0] low_wm_q;
  logic [15:0] high_wm_q;
  logic [1:0]  mode_q, mode_d, mode_a;
  logic        en_q, en_d, en_a;
  logic [15:0] gain_q, gain_d;

  logic               fire;
  logic               check;
  logic [1:0]         report;
  logic [1:0]         rep2;
  logic               rate_load;
  logic               sample_valid;
  logic signed [31:0] product;
  logic [GainIdxW-1:0] gain_idx;

  assign fire       = in_valid_q && room_i;
  assign in_ready_o = !in_valid_q || room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q    <= req_type_i;
      rate_q   <= rate_request_i;
      vol_q    <= volume_percent_i;
      fill_q   <= fill_level_i;
      sample_q <= sample_in_i;
      bend_q   <= buffer_end_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_wm_q  <= 16'd16384;
      high_wm_q <= 16'd49152;
    end else if (cfg_valid_i) begin
      if (cfg_addr_i == CfgLowWatermark) begin
        low_wm_q <= cfg_data_i;
      end else if (cfg_addr_i == CfgHighWatermark) begin
        high_wm_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      en_q   <= 1'b0;
      gain_q <= GainTable[DefaultVolume];
    end else if (fire) begin
      mode_q <= mode_d;
      en_q   <= en_d;
      gain_q <= gain_d;
    end
  end

  assign gain_idx = (vol_q > 8'(VolumeSteps)) ? GainIdxW'(VolumeSteps)
                                              : vol_q[GainIdxW-1:0];
  assign product  = sample_q * $signed({1'b0, gain_q});

  always_comb begin
    mode_a       = mode_q;
    en_a         = en_q;
    gain_d       = gain_q;
    report       = RepNone;
    rate_load    = 1'b0;
    sample_valid = 1'b0;
    check        = 1'b1;
    case (req_q)
      ReqStart: begin
        if (mode_q == ModeIdle) begin
          mode_a    = ModeBuffering;
          report    = RepBuffering;
          rate_load = 1'b1;
        end
      end
      ReqStop: begin
        if (mode_q != ModeIdle) begin
          mode_a = ModeIdle;
          en_a   = 1'b0;
          report = RepStopped;
        end
      end
      ReqVolume: begin
        gain_d = GainTable[gain_idx];
      end
      ReqSample: begin
        sample_valid = (mode_q == ModeRunning);
        check        = bend_q;
      end
      default: begin
      end
    endcase

    mode_d = mode_a;
    en_d   = en_a;
    rep2   = RepNone;
    if (check) begin
      if (mode_a == ModeBuffering && fill_q > high_wm_q) begin
        mode_d = ModeRunning;
        en_d   = 1'b1;
        rep2   = RepRunning;
      end else if (mode_a == ModeRunning && fill_q < low_wm_q) begin
        mode_d = ModeBuffering;
        en_d   = 1'b0;
        rep2   = RepBuffering;
      end
    end

    push_o.valid                = fire;
    push_o.two                  = (rep2 != RepNone);
    push_o.first.mode           = mode_a;
    push_o.first.output_enable  = en_a;
    push_o.first.report         = report;
    push_o.first.rate_load      = rate_load;
    push_o.first.rate_out       = rate_load ? rate_q : 18'd0;
    push_o.first.sample_valid   = sample_valid;
    push_o.first.scaled_sample  = sample_valid ? product[30:15] : 16'sd0;
    push_o.first.last_result    = (rep2 == RepNone);
    push_o.second.mode          = mode_d;
    push_o.second.output_enable = en_d;
    push_o.second.report        = rep2;
    push_o.second.rate_load     = 1'b0;
    push_o.second.rate_out      = 18'd0;
    push_o.second.sample_valid  = 1'b0;
    push_o.second.scaled_sample = 16'sd0;
    push_o.second.last_result   = 1'b1;
  end

endmodule

[src/apbc_out_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apbc_out_queue
// Four-entry result queue; takes up to two results per cycle and drives
// one result beat per cycle to the output side while out_ready_i is high.
// ----------------------------------------------------------------------------
module apbc_out_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  apbc_pkg::push_t   push_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output apbc_pkg::result_t out_o
);
  import apbc_pkg::*;

  result_t     entry_q [4];
  logic [1:0]  wr_ptr_q;
  logic [1:0]  rd_ptr_q;
  logic [2:0]  count_q;
  logic        pop;
  logic [2:0]  push_n;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != 3'd0);
  assign out_o       = entry_q[rd_ptr_q];
  // room for two more after this cycle's pop
  assign room_o      = (count_q <= 3'd2) || ((count_q == 3'd3) && pop);
  assign push_n      = push_i.valid ? (push_i.two ? 3'd2 : 3'd1) : 3'd0;

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      entry_q[wr_ptr_q] <= push_i.first;
      if (push_i.two) begin
        entry_q[wr_ptr_q + 2'd1] <= push_i.second;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      count_q  <= 3'd0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_n[1:0];
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      count_q <= count_q + push_n - {2'b00, pop};
    end
  end

endmodule

[src/audio_playback_buffer_control_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_playback_buffer_control_core
// Playback controller: idle/buffering/running modes with watermark
// hysteresis and q15 volume scaling of samples.
// path: input beat registered in apbc_ctrl, then written to the output queue
// throughput: one input beat per cycle while the queue has room; one result
// beat per cycle while m_axis_tready is high, so two-result items take two beats
// reset: idle, output disabled, gain of half volume, watermarks 16384/49152
// ----------------------------------------------------------------------------
module audio_playback_buffer_control_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // rate_request[17:0], volume_percent[25:18], fill_level[41:26],
  // sample_in[57:42], zero[63:58]
  input  logic [63:0] s_axis_tdata,
  // req_type[2:0]
  input  logic [2:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // mode[1:0], output_enable[2], rate_out[20:3], scaled_sample[36:21],
  // zero[39:37]
  output logic [39:0] m_axis_tdata,
  // report[1:0], rate_load[2], sample_valid[3]
  output logic [3:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i
);
  import apbc_pkg::*;

  push_t   push;
  logic    room;
  result_t res;

  assign cfg_ready_o = 1'b1;

  apbc_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .req_type_i       (s_axis_tuser),
    .rate_request_i   (s_axis_tdata[17:0]),
    .volume_percent_i (s_axis_tdata[25:18]),
    .fill_level_i     (s_axis_tdata[41:26]),
    .sample_in_i      (s_axis_tdata[57:42]),
    .buffer_end_i     (s_axis_tlast),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_data_i       (cfg_data_i),
    .room_i           (room),
    .push_o           (push)
  );

  apbc_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {3'b000, res.scaled_sample, res.rate_out,
                         res.output_enable, res.mode};
  assign m_axis_tuser = {res.sample_valid, res.rate_load, res.report};
  assign m_axis_tlast = res.last_result;

endmodule
